// ----- src/srtf_preemptive_scheduler_unit_assert.svh -----
// Assertion macros for the scheduler.
`ifndef SRTF_PREEMPTIVE_SCHEDULER_UNIT_ASSERT_SVH
`define SRTF_PREEMPTIVE_SCHEDULER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define SRTF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");
`define SRTF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");
`else
`define SRTF_ASSERT_IMP(lbl, ante, cons)
`define SRTF_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- src/srtf_pkg.sv -----
package srtf_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int JOB_COUNT   = 256;
  localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int JAW = $clog2(JOB_COUNT);

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [1:0] EV_FINISH   = 2'd0;
  localparam logic [1:0] EV_DISPATCH = 2'd1;
  localparam logic [1:0] EV_PREEMPT  = 2'd2;
  localparam logic [1:0] EV_SUMMARY  = 2'd3;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  job_id;
    logic [15:0] burst_len;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [7:0]  event_job;
    logic [31:0] turnaround;
    logic [31:0] wait_ticks;
    logic [31:0] response_ticks;
    logic        first_run;
    logic [31:0] now_time;
    logic [31:0] switch_total;
    logic        queue_overflow;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] rem;
  } q_entry_t;

  typedef struct packed {
    logic [31:0] arrival;
    logic [15:0] burst;
    logic        started;
  } job_entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FIN, S_FIN_EMIT, S_SCAN_START, S_SCAN, S_DECIDE,
    S_SHIFT_RD, S_SHIFT_WR, S_APPEND, S_DISP_EMIT, S_SUM
  } state_e;

endpackage

// ----- src/srtf_preemptive_scheduler_unit.sv -----
// Preemptive shortest-remaining-time-first scheduler.
// Input channel (in_valid_i / in_stall_o / in_data_i): an item is either an
// arrival (job id and burst) or a time tick. Output channel (out_valid_o /
// out_stall_i / out_data_o): result items of a tick, in order finish,
// dispatch or preemption, then the tick summary with last set.
// An arrival is taken in the idle state and gives no result. A tick holds
// the input while the queue is scanned and compacted; the queue RAM is read
// at one address a cycle, so the minimum scan reads one entry per cycle and
// the compaction after a dispatch moves each entry with a read state, then
// a write state. Job arrival, burst and started flag live in a second RAM,
// read once for a finish and once for a dispatch.
// The block takes no new item while a tick is in progress. Each result waits
// in the output register; with out_stall_i high the sequencer holds until
// that register frees. After the summary is loaded the block takes items
// again while the summary still waits.
// Reset clears the queue fill, the running job, time, switch count and the
// overflow flag; the RAM contents are left undefined and only read once
// written by an arrival.
`include "srtf_preemptive_scheduler_unit_assert.svh"

module srtf_preemptive_scheduler_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  srtf_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output srtf_pkg::out_item_t out_data_o
);
  import srtf_pkg::*;

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [7:0]      run_id_q, run_id_d;
  logic            run_valid_q, run_valid_d;
  logic [15:0]     run_rem_q, run_rem_d;
  logic [31:0]     clock_q, clock_d;
  logic [31:0]     switch_q, switch_d;
  logic            ovf_q, ovf_d;
  logic [QW-1:0]   idx_q, idx_d;
  logic [QW-1:0]   best_idx_q, best_idx_d;
  logic [15:0]     best_rem_q, best_rem_d;
  logic [7:0]      best_id_q, best_id_d;
  logic            preempt_q, preempt_d;
  logic [7:0]      old_id_q, old_id_d;
  logic [15:0]     old_rem_q, old_rem_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;

  logic            q_we, q_re;
  logic [QW-1:0]   q_waddr, q_raddr;
  q_entry_t        q_wdata, q_rdata;
  logic            j_we, j_re;
  logic [JAW-1:0]  j_waddr, j_raddr;
  job_entry_t      j_wdata, j_rdata;

  logic            in_acc, out_free, id_ok;
  logic [31:0]     tat;

  srtf_ram #(.WIDTH($bits(q_entry_t)), .DEPTH(QUEUE_DEPTH), .AW(QW)) u_queue (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .re_i    (q_re),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  srtf_ram #(.WIDTH($bits(job_entry_t)), .DEPTH(JOB_COUNT), .AW(JAW)) u_jobs (
    .clk_i   (clk_i),
    .we_i    (j_we),
    .waddr_i (j_waddr),
    .wdata_i (j_wdata),
    .re_i    (j_re),
    .raddr_i (j_raddr),
    .rdata_o (j_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign id_ok       = ({24'd0, in_data_i.job_id} < 32'(JOB_COUNT));
  assign tat         = clock_q - j_rdata.arrival;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    run_id_d    = run_id_q;
    run_valid_d = run_valid_q;
    run_rem_d   = run_rem_q;
    clock_d     = clock_q;
    switch_d    = switch_q;
    ovf_d       = ovf_q;
    idx_d       = idx_q;
    best_idx_d  = best_idx_q;
    best_rem_d  = best_rem_q;
    best_id_d   = best_id_q;
    preempt_d   = preempt_q;
    old_id_d    = old_id_q;
    old_rem_d   = old_rem_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    q_we = 1'b0; q_re = 1'b0;
    q_waddr = '0; q_raddr = '0; q_wdata = '0;
    j_we = 1'b0; j_re = 1'b0;
    j_waddr = '0; j_raddr = '0; j_wdata = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data_i.opcode == OP_TICK) begin
            state_d = S_FIN;
          end else if (id_ok) begin
            if (count_q == CW'(QUEUE_DEPTH)) begin
              // drop the arrival, keep the flag until reset
              ovf_d = 1'b1;
            end else begin
              j_we    = 1'b1;
              j_waddr = JAW'(in_data_i.job_id);
              j_wdata = '{arrival: clock_q, burst: in_data_i.burst_len, started: 1'b0};
              q_we    = 1'b1;
              q_waddr = QW'(count_q);
              q_wdata = '{id: in_data_i.job_id, rem: in_data_i.burst_len};
              count_d = count_q + CW'(1);
            end
          end
        end
      end
      S_FIN: begin
        if (run_valid_q && run_rem_q == 16'd0) begin
          j_re    = 1'b1;
          j_raddr = JAW'(run_id_q);
          state_d = S_FIN_EMIT;
        end else begin
          state_d = S_SCAN_START;
        end
      end
      S_FIN_EMIT: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d                = '0;
          out_d.event_kind     = EV_FINISH;
          out_d.event_job      = run_id_q;
          out_d.turnaround     = tat;
          out_d.wait_ticks     = tat - {16'd0, j_rdata.burst};
          out_d.now_time       = clock_q;
          out_d.switch_total   = switch_q;
          out_d.queue_overflow = ovf_q;
          run_valid_d          = 1'b0;
          state_d              = S_SCAN_START;
        end
      end
      S_SCAN_START: begin
        if (count_q == '0) begin
          state_d = S_SUM;
        end else begin
          q_re    = 1'b1;
          q_raddr = '0;
          idx_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // first strictly smaller entry wins, so ties keep the earliest
        if (idx_q == '0 || q_rdata.rem < best_rem_q) begin
          best_idx_d = idx_q;
          best_rem_d = q_rdata.rem;
          best_id_d  = q_rdata.id;
        end
        if (CW'(idx_q) + CW'(1) < count_q) begin
          q_re    = 1'b1;
          q_raddr = idx_q + QW'(1);
          idx_d   = idx_q + QW'(1);
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!run_valid_q || best_rem_q < run_rem_q) begin
          preempt_d   = run_valid_q;
          old_id_d    = run_id_q;
          old_rem_d   = run_rem_q;
          if (run_valid_q) begin
            switch_d = switch_q + 32'd1;
          end
          run_id_d    = best_id_q;
          run_rem_d   = best_rem_q;
          run_valid_d = 1'b1;
          j_re        = 1'b1;
          j_raddr     = JAW'(best_id_q);
          idx_d       = best_idx_q;
          state_d     = S_SHIFT_RD;
        end else begin
          state_d = S_SUM;
        end
      end
      S_SHIFT_RD: begin
        // close the gap left by the dispatched entry
        if (CW'(idx_q) + CW'(1) < count_q) begin
          q_re    = 1'b1;
          q_raddr = idx_q + QW'(1);
          state_d = S_SHIFT_WR;
        end else begin
          state_d = S_APPEND;
        end
      end
      S_SHIFT_WR: begin
        q_we    = 1'b1;
        q_waddr = idx_q;
        q_wdata = q_rdata;
        idx_d   = idx_q + QW'(1);
        state_d = S_SHIFT_RD;
      end
      S_APPEND: begin
        if (preempt_q) begin
          // preempted job goes to the tail, fill stays the same
          q_we    = 1'b1;
          q_waddr = QW'(count_q - CW'(1));
          q_wdata = '{id: old_id_q, rem: old_rem_q};
        end else begin
          count_d = count_q - CW'(1);
        end
        state_d = S_DISP_EMIT;
      end
      S_DISP_EMIT: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d                = '0;
          out_d.event_kind     = preempt_q ? EV_PREEMPT : EV_DISPATCH;
          out_d.event_job      = run_id_q;
          out_d.first_run      = !j_rdata.started;
          out_d.response_ticks = j_rdata.started ? 32'd0 : tat;
          out_d.now_time       = clock_q;
          out_d.switch_total   = switch_q;
          out_d.queue_overflow = ovf_q;
          if (!j_rdata.started) begin
            j_we    = 1'b1;
            j_waddr = JAW'(run_id_q);
            j_wdata = '{arrival: j_rdata.arrival, burst: j_rdata.burst, started: 1'b1};
          end
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d                = '0;
          out_d.event_kind     = EV_SUMMARY;
          out_d.now_time       = clock_q;
          out_d.switch_total   = switch_q;
          out_d.queue_overflow = ovf_q;
          out_d.last           = 1'b1;
          // advance time and run the current job for one tick
          clock_d = clock_q + 32'd1;
          if (run_valid_q && run_rem_q != 16'd0) begin
            run_rem_d = run_rem_q - 16'd1;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      run_id_q    <= '0;
      run_valid_q <= 1'b0;
      run_rem_q   <= '0;
      clock_q     <= '0;
      switch_q    <= '0;
      ovf_q       <= 1'b0;
      preempt_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      run_id_q    <= run_id_d;
      run_valid_q <= run_valid_d;
      run_rem_q   <= run_rem_d;
      clock_q     <= clock_d;
      switch_q    <= switch_d;
      ovf_q       <= ovf_d;
      preempt_q   <= preempt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    best_idx_q <= best_idx_d;
    best_rem_q <= best_rem_d;
    best_id_q  <= best_id_d;
    old_id_q   <= old_id_d;
    old_rem_q  <= old_rem_d;
    out_q      <= out_d;
  end

  `SRTF_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(QUEUE_DEPTH))
  `SRTF_ASSERT_IMP(a_switch_src, switch_q != $past(switch_q), $past(state_q) == S_DECIDE)
  `SRTF_ASSERT_NXT(a_sum_to_idle, state_q == S_SUM && out_free, state_q == S_IDLE)
  `SRTF_ASSERT_IMP(a_last_kind, out_valid_o && out_data_o.last,
                   out_data_o.event_kind == EV_SUMMARY)

endmodule

// ----- src/srtf_ram.sv -----
module srtf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
